[rtl/two_way_sorted_merge_unit_defines.svh]
// Assertion macros shared by the merge unit
`ifndef TWO_WAY_SORTED_MERGE_UNIT_DEFINES_SVH
`define TWO_WAY_SORTED_MERGE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TSMU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TSMU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/tsmu_pkg.sv]
package tsmu_pkg;

	localparam int VALUE_W    = 32;
	localparam int DEPTH_DEF  = 16;
	localparam int CMDQ_DEPTH = 2;
	localparam int RESQ_DEPTH = 2;

	// input kind codes
	localparam logic [1:0] KIND_FIRST  = 2'd0;
	localparam logic [1:0] KIND_SECOND = 2'd1;
	localparam logic [1:0] KIND_MERGE  = 2'd2;

	typedef enum logic [1:0] {
		OP_APPEND_A,
		OP_APPEND_B,
		OP_MERGE
	} op_t;

	typedef struct packed {
		op_t                       op;
		logic signed [VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} res_t;

	// front to back command channel
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_chan_t;

	// back-end activity, visible to the top level
	typedef struct packed {
		logic merging;
		logic res_push;
		logic res_last;
	} back_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRIME,
		ST_RUN
	} back_state_t;

endpackage

[rtl/tsmu_ram.sv]
module tsmu_ram #(
	parameter int W = 32,
	parameter int D = 16,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [D];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/tsmu_fifo.sv]
module tsmu_fifo #(
	parameter int W = 8,
	parameter int D = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	localparam int AW = (D > 1) ? $clog2(D) : 1;
	localparam int CW = $clog2(D + 1);

	logic [W-1:0]  mem_q [D];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(D));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(D - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(D - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

[rtl/tsmu_front.sv]
module tsmu_front import tsmu_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  logic [1:0]                kind,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      full,
	output cmd_chan_t                 chan,
	input  logic                      cmd_pop
);

	cmd_t cmd_in, cmd_out;
	logic known, q_empty;

	// decode kind; the unused code is accepted and dropped here
	always_comb begin
		cmd_in.value = value;
		cmd_in.op    = OP_APPEND_A;
		known        = 1'b1;
		unique case (kind)
			KIND_FIRST:  cmd_in.op = OP_APPEND_A;
			KIND_SECOND: cmd_in.op = OP_APPEND_B;
			KIND_MERGE:  cmd_in.op = OP_MERGE;
			default:     known     = 1'b0;
		endcase
	end

	// command queue toward the back end
	tsmu_fifo #(
		.W($bits(cmd_t)),
		.D(CMDQ_DEPTH)
	) u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push && known),
		.din   (cmd_in),
		.full  (full),
		.pop   (cmd_pop),
		.dout  (cmd_out),
		.empty (q_empty)
	);

	assign chan.valid = !q_empty;
	assign chan.cmd   = cmd_out;

endmodule

[rtl/tsmu_back.sv]
module tsmu_back import tsmu_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmd_chan_t                  chan,
	output logic                       cmd_pop,
	output logic signed [VALUE_W-1:0]  merged_value,
	output logic                       last,
	output logic                       empty,
	input  logic                       pop,
	output back_stat_t                 stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	back_state_t         state_q, state_d;
	logic [CW-1:0]       cnt_a_q, cnt_b_q, i_q, j_q, i_next, j_next;
	logic                we_a, we_b;
	logic [AW-1:0]       raddr_a, raddr_b;
	logic [VALUE_W-1:0]  rd_a, rd_b;
	logic                have_a, have_b, take_a, step, run_last;
	logic                res_full, res_empty;
	res_t                res_in, res_out;

	tsmu_ram #(.W(VALUE_W), .D(DEPTH)) u_ram_a (
		.clk  (clk),
		.we   (we_a),
		.waddr(cnt_a_q[AW-1:0]),
		.wdata(chan.cmd.value),
		.raddr(raddr_a),
		.rdata(rd_a)
	);

	tsmu_ram #(.W(VALUE_W), .D(DEPTH)) u_ram_b (
		.clk  (clk),
		.we   (we_b),
		.waddr(cnt_b_q[AW-1:0]),
		.wdata(chan.cmd.value),
		.raddr(raddr_b),
		.rdata(rd_b)
	);

	// head selection; on equal heads the second list goes first
	assign have_a   = (i_q < cnt_a_q);
	assign have_b   = (j_q < cnt_b_q);
	assign take_a   = have_a && (!have_b || ($signed(rd_a) < $signed(rd_b)));
	assign step     = (state_q == ST_RUN) && !res_full;
	assign i_next   = i_q + CW'(step && take_a);
	assign j_next   = j_q + CW'(step && !take_a);
	assign run_last = (i_next == cnt_a_q) && (j_next == cnt_b_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (chan.valid && chan.cmd.op == OP_MERGE &&
				    (cnt_a_q != '0 || cnt_b_q != '0)) begin
					state_d = ST_PRIME;
				end
			end
			ST_PRIME: state_d = ST_RUN;
			ST_RUN: begin
				if (step && run_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd_pop = 1'b0;
		we_a    = 1'b0;
		we_b    = 1'b0;
		raddr_a = '0;
		raddr_b = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_pop = chan.valid;
				we_a    = chan.valid && chan.cmd.op == OP_APPEND_A &&
				          cnt_a_q != CW'(DEPTH);
				we_b    = chan.valid && chan.cmd.op == OP_APPEND_B &&
				          cnt_b_q != CW'(DEPTH);
			end
			ST_PRIME: begin
				raddr_a = '0;
				raddr_b = '0;
			end
			ST_RUN: begin
				// fetch the heads for the next step; held while stalled
				raddr_a = i_next[AW-1:0];
				raddr_b = j_next[AW-1:0];
			end
			default: ;
		endcase
	end

	// state, counts and head indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			if (we_a) begin
				cnt_a_q <= cnt_a_q + CW'(1);
			end
			if (we_b) begin
				cnt_b_q <= cnt_b_q + CW'(1);
			end
			if (state_q == ST_RUN) begin
				i_q <= i_next;
				j_q <= j_next;
				if (step && run_last) begin
					cnt_a_q <= '0;
					cnt_b_q <= '0;
				end
			end else begin
				i_q <= '0;
				j_q <= '0;
			end
		end
	end

	// result queue
	assign res_in.value = take_a ? rd_a : rd_b;
	assign res_in.last  = run_last;

	tsmu_fifo #(
		.W($bits(res_t)),
		.D(RESQ_DEPTH)
	) u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (step),
		.din   (res_in),
		.full  (res_full),
		.pop   (pop),
		.dout  (res_out),
		.empty (res_empty)
	);

	assign merged_value = res_out.value;
	assign last         = res_out.last;
	assign empty        = res_empty;

	assign stat.merging  = (state_q == ST_RUN);
	assign stat.res_push = step;
	assign stat.res_last = run_last;

endmodule

[rtl/two_way_sorted_merge_unit.sv]
// Two-way merge of sorted lists.
// Input queue: push/full with kind and value. kind 0 appends value to the
// first list, kind 1 to the second, kind 2 requests a merge; kind 3 is
// taken and ignored. Appends past DEPTH elements per list are dropped.
// Result queue: empty/pop with merged_value and last; last marks the final
// element of a merge run. A merge of two empty lists gives no result.
// An append passes through the command queue before it is written to its
// list memory. The first result of a merge passes through the command
// queue, the prime state that reads both list heads, and the result queue.
// Throughput: one append per cycle while the back end is idle; a merge
// emits one result per cycle while the result queue has room, paced by the
// registered read ports of the two list memories. Items pushed during a
// merge wait in a two-entry command queue, then full rises.
// Reset clears both counts, both queues and the sequencer; list contents
// are not cleared. When the receiver stalls, the two-entry result queue
// fills and the merge pauses in place without losing its position.
module two_way_sorted_merge_unit import tsmu_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [1:0]                 kind,
	input  logic signed [VALUE_W-1:0]  value,
	output logic                       empty,
	input  logic                       pop,
	output logic signed [VALUE_W-1:0]  merged_value,
	output logic                       last
);

	`include "two_way_sorted_merge_unit_defines.svh"

	cmd_chan_t  chan;
	logic       cmd_pop;
	back_stat_t stat;

	tsmu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.kind   (kind),
		.value  (value),
		.full   (full),
		.chan   (chan),
		.cmd_pop(cmd_pop)
	);

	tsmu_back #(.DEPTH(DEPTH)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.chan        (chan),
		.cmd_pop     (cmd_pop),
		.merged_value(merged_value),
		.last        (last),
		.empty       (empty),
		.pop         (pop),
		.stat        (stat)
	);

	// back end takes commands only when the queue holds one
	`TSMU_ASSERT_SAME(a_cmd_pop_valid, cmd_pop, chan.valid, "command popped from empty queue")
	// results are produced only during a merge run
	`TSMU_ASSERT_SAME(a_push_in_run, stat.res_push, stat.merging, "result outside merge run")
	// the run ends right after its final result
	`TSMU_ASSERT_NEXT(a_last_ends_run, stat.res_push && stat.res_last, !stat.merging,
		"merge run continued after last result")

endmodule

[test/two_way_sorted_merge_unit_tb.sv]
`timescale 1ns / 1ps

module two_way_sorted_merge_unit_tb;
	import tsmu_pkg::*;

	localparam int DEPTH          = DEPTH_DEF;
	localparam int RANDOM_ITEMS   = 200;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int TAIL_CYCLES    = 20;
	localparam int MAX_REPORTS    = 10;

	// kind code with no function, taken and ignored by the block
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef enum int {
		GEN_NARROW,
		GEN_WIDE,
		GEN_UNSORTED
	} gen_mode_t;

	typedef logic signed [VALUE_W-1:0] val_q_t[$];

	// Tracks both lists and the merged sequence still owed by the block
	class merge_scoreboard;
		logic signed [VALUE_W-1:0] first_q[$];
		logic signed [VALUE_W-1:0] second_q[$];
		res_t merged_q[$];
		int errors;
		int inputs;
		int merges;
		int results;
		int dropped;
		int longest_run;

		function void flag(string msg);
			errors++;
			if (errors <= MAX_REPORTS) begin
				$display("MISMATCH @%0t: %s", $realtime, msg);
			end
		endfunction

		// accepted input transaction: update lists, or expand a merge
		function void note_input(logic [1:0] k, logic signed [VALUE_W-1:0] v);
			int i;
			int j;
			int n;
			res_t r;
			inputs++;
			case (k)
			KIND_FIRST: begin
				if (first_q.size() < DEPTH) first_q.push_back(v);
				else dropped++;
			end
			KIND_SECOND: begin
				if (second_q.size() < DEPTH) second_q.push_back(v);
				else dropped++;
			end
			KIND_MERGE: begin
				i = 0;
				j = 0;
				n = 0;
				merges++;
				while (i < first_q.size() || j < second_q.size()) begin
					// second list wins ties
					if (j >= second_q.size() ||
						(i < first_q.size() && first_q[i] < second_q[j])) begin
						r.value = first_q[i];
						i++;
					end else begin
						r.value = second_q[j];
						j++;
					end
					r.last = (i >= first_q.size() && j >= second_q.size());
					merged_q.push_back(r);
					n++;
				end
				if (n > longest_run) longest_run = n;
				first_q.delete();
				second_q.delete();
			end
			default: begin
			end
			endcase
		endfunction

		// accepted result transaction against the oldest expectation
		function void check_result(logic signed [VALUE_W-1:0] v, logic l);
			res_t want;
			results++;
			if (merged_q.size() == 0) begin
				flag($sformatf("unexpected result merged_value=%0d last=%0b", v, l));
				return;
			end
			want = merged_q.pop_front();
			if (v !== want.value) begin
				flag($sformatf("merged_value exp %0d got %0d", want.value, v));
			end
			if (l !== want.last) begin
				flag($sformatf("last exp %0b got %0b (merged_value %0d)",
					want.last, l, want.value));
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      push;
	logic                      full;
	logic [1:0]                kind;
	logic signed [VALUE_W-1:0] value;
	logic                      empty;
	logic                      pop = 1'b0;
	logic signed [VALUE_W-1:0] merged_value;
	logic                      last;

	merge_scoreboard sb;
	int rand_items;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;
	int idle_cycles = 0;

	two_way_sorted_merge_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.kind         (kind),
		.value        (value),
		.empty        (empty),
		.pop          (pop),
		.merged_value (merged_value),
		.last         (last)
	);

	always #10 clk = ~clk;

	// offer one item, with random idle cycles ahead of it
	task automatic send_item(logic [1:0] k, logic signed [VALUE_W-1:0] v);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push  <= 1'b1;
		kind  <= k;
		value <= v;
		do @(posedge clk); while (full);
		sb.note_input(k, v);
	endtask

	// ascending or unsorted list: narrow gives ties and duplicates, wide all bits
	function automatic val_q_t make_list(int n, gen_mode_t mode, int base);
		val_q_t q;
		longint cur;
		cur = (mode == GEN_WIDE) ? longint'($signed($urandom)) : longint'(base);
		for (int k = 0; k < n; k++) begin
			if (mode == GEN_UNSORTED) begin
				q.push_back($urandom);
			end else begin
				q.push_back(cur[31:0]);
				cur += (mode == GEN_WIDE) ? $urandom_range(0, 1 << 27) : $urandom_range(0, 2);
				if (cur > 64'sd2147483647) cur = 64'sd2147483647;
			end
		end
		return q;
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return 0;
		if (r < 80) return $urandom_range(1, 6);
		if (r < 90) return $urandom_range(7, DEPTH - 1);
		return $urandom_range(DEPTH, DEPTH + 3);
	endfunction

	// load two lists in random interleave with some noise, then merge
	task automatic run_sequence(int n_a, int n_b);
		val_q_t qa;
		val_q_t qb;
		gen_mode_t mode;
		int r;
		int base;
		r = $urandom_range(0, 9);
		mode = (r < 6) ? GEN_NARROW : (r < 9) ? GEN_WIDE : GEN_UNSORTED;
		base = $urandom_range(0, 8) - 4;
		qa = make_list(n_a, mode, base);
		qb = make_list(n_b, mode, base);
		while (qa.size() != 0 || qb.size() != 0) begin
			if ($urandom_range(0, 99) < 6) begin
				send_item(KIND_UNUSED, $urandom);
			end else if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(0, 1) == 0)) begin
				send_item(KIND_FIRST, qa.pop_front());
				rand_items++;
			end else begin
				send_item(KIND_SECOND, qb.pop_front());
				rand_items++;
			end
		end
		send_item(KIND_MERGE, $urandom);
		rand_items++;
	endtask

	// receiver: check each popped result, stall at random or for a long hold
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) sb.check_result(merged_value, last);
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// watchdog on cycles without any accepted transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("two_way_sorted_merge_unit_tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		sb = new;
		arst_n = 1'b0;
		push = 1'b0;
		kind = KIND_FIRST;
		value = '0;
		rand_items = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty merge, ignored kind
		send_item(KIND_MERGE, 32'sd0);
		send_item(KIND_UNUSED, 32'hFFFF_FFFF);
		// extremes on both lists, ties at each of them, duplicate in second list
		send_item(KIND_FIRST, 32'sh8000_0000);
		send_item(KIND_SECOND, 32'sh8000_0000);
		send_item(KIND_FIRST, 32'sd7);
		send_item(KIND_SECOND, 32'sd7);
		send_item(KIND_SECOND, 32'sd7);
		send_item(KIND_FIRST, 32'sh7FFF_FFFF);
		send_item(KIND_SECOND, 32'sh7FFF_FFFF);
		send_item(KIND_MERGE, 32'hFFFF_FFFF);
		// only the first list, then only the second
		send_item(KIND_FIRST, -32'sd1);
		send_item(KIND_MERGE, 32'sd0);
		send_item(KIND_SECOND, 32'sd1);
		send_item(KIND_SECOND, 32'sd2);
		send_item(KIND_MERGE, 32'sd0);
		// descending first list, merged and checked by the scoreboard
		send_item(KIND_FIRST, 32'sd10);
		send_item(KIND_FIRST, -32'sd10);
		send_item(KIND_SECOND, 32'sd0);
		send_item(KIND_MERGE, 32'sd0);
		// merge right after a merge: nothing left to emit
		send_item(KIND_MERGE, 32'sd0);

		// long receiver hold while an overfull list is loaded and merged
		hold_left = HOLD_CYCLES;
		run_sequence(DEPTH + 2, $urandom_range(0, DEPTH));

		// random part in phases of idling
		while (rand_items < RANDOM_ITEMS) begin
			case (rand_items * 4 / RANDOM_ITEMS)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 63;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 63;
			end
			default: begin
				send_idle_pct = 12;
				recv_stall_pct = 12;
			end
			endcase
			run_sequence(pick_len(), pick_len());
		end
		push <= 1'b0;

		// drain, then allow for any late stray result
		while (sb.merged_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.merged_q.size() != 0) begin
			sb.flag($sformatf("%0d expected results never arrived", sb.merged_q.size()));
		end

		$display("covered %0d input transactions, %0d merges (longest %0d results)",
			sb.inputs, sb.merges, sb.longest_run);
		$display("%0d dropped appends, checked %0d results, %0d mismatches",
			sb.dropped, sb.results, sb.errors);
		if (sb.errors == 0) begin
			$display("two_way_sorted_merge_unit_tb: done, clean");
		end else begin
			$display("two_way_sorted_merge_unit_tb: done, errors");
		end
		$finish;
	end

endmodule
